[sv/mm4_pkg.sv]
// Shared constants and types for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

    localparam int DIM         = 4;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CELLS       = DIM * DIM;

    localparam int IDX_W  = $clog2(DIM);
    localparam int CELL_W = $clog2(CELLS);
    localparam int STEP_W = CELL_W + IDX_W;
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int ACC_W  = PROD_W + IDX_W;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [CELL_W-1:0]             t_cell;
    typedef logic [IDX_W-1:0]              t_idx;

    // Tag that travels with a product through the read, multiply and sum stages.
    typedef struct packed {
        logic  valid;
        t_cell elem;
        t_idx  k;
    } t_tag;

endpackage

[sv/mm4_ifs.sv]
// Handshake interfaces for the element pairs in and the product elements out.
interface mm4_in_if;
    import mm4_pkg::*;

    logic   valid;
    logic   ready;
    t_value a_value;
    t_value b_value;
    logic   last_in;

    modport source (output valid, a_value, b_value, last_in, input ready);
    modport sink   (input valid, a_value, b_value, last_in, output ready);
endinterface

interface mm4_out_if;
    import mm4_pkg::*;

    logic   valid;
    logic   ready;
    t_value product_value;
    t_cell  out_index;
    logic   last_out;

    modport source (output valid, product_value, out_index, last_out, input ready);
    modport sink   (input valid, product_value, out_index, last_out, output ready);
endinterface

[sv/matrix4_multiply_fixed.sv]
// After the sixteenth item, each product passes the memory read, multiply, accumulate and output registers.
// All sixteen items of a pair are loaded before computing starts, and no item is taken while reading,
// with the single shared multiplier reading one A and one B element per cycle unless the output stalls.
// Loading of the next pair overlaps the last products draining from the pipeline.
// Output backpressure freezes the whole compute pipeline.
// Reset (synchronous, active low) clears the load index and all valid flags; memories keep data.
module matrix4_multiply_fixed (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm4_in_if.sink    i_in,
    mm4_out_if.source o_out
);
    import mm4_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CELLS * DIM - 1);
    localparam t_cell             LAST_CELL = CELL_W'(CELLS - 1);
    localparam t_idx              LAST_K    = IDX_W'(DIM - 1);

    t_value mem_a [CELLS];
    t_value mem_b [CELLS];

    logic              r_busy;
    t_cell             r_load;
    logic [STEP_W-1:0] r_step;

    t_value                    r_a_rd, r_b_rd;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_tag                      r_s1, r_s2;
    logic                      r_s3_valid;
    t_cell                     r_s3_cell;

    logic   r_o_valid;
    t_value r_o_value;
    t_cell  r_o_index;
    logic   r_o_last;

    logic                    w_en;
    logic                    w_load;
    t_idx                    w_k, w_i, w_j;
    t_cell                   w_cell, w_a_addr, w_b_addr;
    logic signed [ACC_W-1:0] w_shift;
    logic                    w_ovf_hi, w_ovf_lo;
    t_value                  w_sat;

    assign w_en   = !r_o_valid || o_out.ready;
    assign w_load = i_in.valid && i_in.ready;

    assign i_in.ready          = !r_busy;
    assign o_out.valid         = r_o_valid;
    assign o_out.product_value = r_o_value;
    assign o_out.out_index     = r_o_index;
    assign o_out.last_out      = r_o_last;

    // Step walks cells in index order, with the dot-product term k in the low bits.
    assign w_k      = r_step[IDX_W-1:0];
    assign w_cell   = r_step[STEP_W-1:IDX_W];
    assign w_i      = w_cell[IDX_W-1:0];
    assign w_j      = w_cell[CELL_W-1:IDX_W];
    assign w_a_addr = CELL_W'(w_i) + CELL_W'(DIM) * CELL_W'(w_k);
    assign w_b_addr = CELL_W'(w_k) + CELL_W'(DIM) * CELL_W'(w_j);

    // The exact sum shifted with floor, then clamped to the output range.
    assign w_shift  = r_acc >>> FRAC_BITS;
    assign w_ovf_hi = !w_shift[ACC_W-1] && (|w_shift[ACC_W-2:VALUE_WIDTH-1]);
    assign w_ovf_lo = w_shift[ACC_W-1] && !(&w_shift[ACC_W-2:VALUE_WIDTH-1]);

    always_comb begin
        if (w_ovf_hi) begin
            w_sat = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else if (w_ovf_lo) begin
            w_sat = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            w_sat = w_shift[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem_a[r_load] <= i_in.a_value;
            mem_b[r_load] <= i_in.b_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_busy) begin
            r_a_rd <= mem_a[w_a_addr];
            r_b_rd <= mem_b[w_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= '0;
            r_step <= '0;
        end else begin
            if (w_load) begin
                r_load <= r_load + 1'b1;
                if (r_load == LAST_CELL) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                end
            end else if (w_en && r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_s2       <= '0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_en) begin
            r_s1       <= '{valid: r_busy, elem: w_cell, k: w_k};
            r_s2       <= r_s1;
            r_s3_valid <= r_s2.valid && (r_s2.k == LAST_K);
            r_o_valid  <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod    <= PROD_W'(r_a_rd) * PROD_W'(r_b_rd);
            r_s3_cell <= r_s2.elem;
            if (r_s2.valid) begin
                r_acc <= ((r_s2.k == '0) ? '0 : r_acc) + ACC_W'(r_prod);
            end
            r_o_value <= w_sat;
            r_o_index <= r_s3_cell;
            r_o_last  <= (r_s3_cell == LAST_CELL);
        end
    end

    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_en && r_step == LAST_STEP) |=> !r_busy)
        else $error("compute did not stop after the last read");

    a_busy_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ($past(w_load) && $past(r_load) == LAST_CELL))
        else $error("compute started without the last item loaded");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !w_load)
        else $error("item written while the matrices are being read");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> (r_o_index == LAST_CELL))
        else $error("last marker on a result that is not the final element");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_acc) && $stable(r_s2)))
        else $error("pipeline moved under output backpressure");

endmodule
